// ===== rtl/soil_moisture_iir_lowpass_core_macros.svh =====
// Assertion macros used by the port checker of the soil moisture filter.
`ifndef SOIL_MOISTURE_IIR_LOWPASS_CORE_MACROS_SVH
`define SOIL_MOISTURE_IIR_LOWPASS_CORE_MACROS_SVH

// Implication to the next cycle, ignored while reset is held.
`define SMIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("soil moisture filter: next-cycle check failed");

// Implication in the same cycle, ignored while reset is held.
`define SMIL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("soil moisture filter: same-cycle check failed");

// Implication to the next cycle that also holds across reset.
`define SMIL_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("soil moisture filter: reset check failed");

`endif

// ===== rtl/smil_pkg.sv =====
// Types and constants shared by the soil moisture low-pass filter.
`timescale 1ns / 1ps
`default_nettype none

package smil_pkg;

    localparam int ADC_IN_W   = 10;
    localparam int RAW_W      = 23;
    localparam int SAMPLE_W   = 25;
    localparam int COEF_W     = 34;
    localparam int ACC_W      = 62;
    localparam int HIST_DEPTH = 4;
    localparam int IDX_W      = 3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 25'sh0FFFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 25'sh1000000;

    typedef enum logic [IDX_W-1:0] {
        REG_NUM_OUTER  = 3'd0,
        REG_NUM_MID    = 3'd1,
        REG_NUM_CENTER = 3'd2,
        REG_DEN_FIRST  = 3'd3,
        REG_DEN_SECOND = 3'd4,
        REG_DEN_THIRD  = 3'd5,
        REG_DEN_FOURTH = 3'd6
    } t_reg_idx;

    localparam logic signed [COEF_W-1:0] RST_NUM_OUTER  = 34'sd14274;
    localparam logic signed [COEF_W-1:0] RST_NUM_MID    = 34'sd57096;
    localparam logic signed [COEF_W-1:0] RST_NUM_CENTER = 34'sd85644;
    localparam logic signed [COEF_W-1:0] RST_DEN_FIRST  = -34'sd3942489006;
    localparam logic signed [COEF_W-1:0] RST_DEN_SECOND = 34'sd5441721835;
    localparam logic signed [COEF_W-1:0] RST_DEN_THIRD  = -34'sd3345744010;
    localparam logic signed [COEF_W-1:0] RST_DEN_FOURTH = 34'sd772997828;

    typedef struct packed {
        logic                mode;
        logic [ADC_IN_W-1:0] adc_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_percent;
        logic [RAW_W-1:0]           raw_percent;
    } t_out_word;

    typedef struct packed {
        logic                       mode;
        logic [RAW_W-1:0]           raw_percent;
        logic signed [SAMPLE_W-1:0] sample;
    } t_conv_word;

endpackage

`default_nettype wire

// ===== rtl/soil_moisture_iir_lowpass_core.sv =====
// Top level of the soil moisture percent converter and fourth-order low-pass filter.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one word per clock while o_in_stall is low and returns one result word per input
// word, in order. Each word passes the three converter stage registers and then the output
// register before its result is offered. Three pipeline stages turn the reading into percent;
// the fourth runs the filter, whose feedback path (seven coefficient multiplies summed, rounded
// and saturated combinationally) sets the clock frequency. The user must write coefficients
// through the configuration port while no word is in flight; the block does not enforce this.
module soil_moisture_iir_lowpass_core #(
    parameter int COEF_FRAC_BITS   = 30,
    parameter int SAMPLE_FRAC_BITS = 16,
    parameter int ADC_BITS         = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  smil_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output smil_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [smil_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [smil_pkg::COEF_W-1:0]        i_cfg_data
);
    import smil_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

    logic                       conv_valid;
    logic                       conv_stall;
    t_conv_word                 conv_word;
    logic                       ready_out;
    logic                       fire;

    logic signed [COEF_W-1:0]   r_num_outer;
    logic signed [COEF_W-1:0]   r_num_mid;
    logic signed [COEF_W-1:0]   r_num_center;
    logic signed [COEF_W-1:0]   r_den_first;
    logic signed [COEF_W-1:0]   r_den_second;
    logic signed [COEF_W-1:0]   r_den_third;
    logic signed [COEF_W-1:0]   r_den_fourth;
    logic signed [SAMPLE_W-1:0] r_xh [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] r_yh [HIST_DEPTH];
    logic                       r_out_valid;
    t_out_word                  r_out_word;

    logic signed [SAMPLE_W:0]   sum_outer;
    logic signed [SAMPLE_W:0]   sum_mid;
    logic signed [ACC_W-1:0]    p_outer;
    logic signed [ACC_W-1:0]    p_mid;
    logic signed [ACC_W-1:0]    p_center;
    logic signed [ACC_W-1:0]    p_y1;
    logic signed [ACC_W-1:0]    p_y2;
    logic signed [ACC_W-1:0]    p_y3;
    logic signed [ACC_W-1:0]    p_y4;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    shifted;
    logic [ACC_W-SAMPLE_W:0]    top_bits;
    logic signed [SAMPLE_W-1:0] n_y;
    logic signed [SAMPLE_W-1:0] n_filtered;
    t_out_word                  n_out_word;

    smil_percent_conv #(
        .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS),
        .ADC_BITS        (ADC_BITS)
    ) u_conv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_stall(o_in_stall),
        .i_word (i_in_word),
        .o_valid(conv_valid),
        .i_stall(conv_stall),
        .o_word (conv_word)
    );

    assign ready_out   = !r_out_valid || !i_out_stall;
    assign conv_stall  = !ready_out;
    assign fire        = conv_valid && ready_out;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign sum_outer = {conv_word.sample[SAMPLE_W-1], conv_word.sample}
                     + {r_xh[3][SAMPLE_W-1], r_xh[3]};
    assign sum_mid   = {r_xh[0][SAMPLE_W-1], r_xh[0]} + {r_xh[2][SAMPLE_W-1], r_xh[2]};

    assign p_outer  = ACC_W'(r_num_outer) * ACC_W'(sum_outer);
    assign p_mid    = ACC_W'(r_num_mid) * ACC_W'(sum_mid);
    assign p_center = ACC_W'(r_num_center) * ACC_W'(r_xh[1]);
    assign p_y1     = ACC_W'(r_den_first) * ACC_W'(r_yh[0]);
    assign p_y2     = ACC_W'(r_den_second) * ACC_W'(r_yh[1]);
    assign p_y3     = ACC_W'(r_den_third) * ACC_W'(r_yh[2]);
    assign p_y4     = ACC_W'(r_den_fourth) * ACC_W'(r_yh[3]);

    always_comb begin
        acc      = p_outer + p_mid + p_center - p_y1 - p_y2 - p_y3 - p_y4 + ROUND;
        shifted  = acc >>> COEF_FRAC_BITS;
        top_bits = shifted[ACC_W-1:SAMPLE_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            n_y = shifted[SAMPLE_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            n_y = SAMPLE_MIN;
        end else begin
            n_y = SAMPLE_MAX;
        end
        if (conv_word.mode) begin
            n_filtered = conv_word.sample;
        end else begin
            n_filtered = n_y;
        end
        n_out_word.filtered_percent = n_filtered;
        n_out_word.raw_percent      = conv_word.raw_percent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_num_outer  <= RST_NUM_OUTER;
            r_num_mid    <= RST_NUM_MID;
            r_num_center <= RST_NUM_CENTER;
            r_den_first  <= RST_DEN_FIRST;
            r_den_second <= RST_DEN_SECOND;
            r_den_third  <= RST_DEN_THIRD;
            r_den_fourth <= RST_DEN_FOURTH;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else begin
            if (ready_out) begin
                r_out_valid <= conv_valid;
            end
            if (fire) begin
                if (conv_word.mode) begin
                    for (int i = 0; i < HIST_DEPTH; i++) begin
                        r_xh[i] <= conv_word.sample;
                        r_yh[i] <= conv_word.sample;
                    end
                end else begin
                    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                        r_xh[i] <= r_xh[i-1];
                        r_yh[i] <= r_yh[i-1];
                    end
                    r_xh[0] <= conv_word.sample;
                    r_yh[0] <= n_y;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NUM_OUTER:  r_num_outer  <= i_cfg_data;
                    REG_NUM_MID:    r_num_mid    <= i_cfg_data;
                    REG_NUM_CENTER: r_num_center <= i_cfg_data;
                    REG_DEN_FIRST:  r_den_first  <= i_cfg_data;
                    REG_DEN_SECOND: r_den_second <= i_cfg_data;
                    REG_DEN_THIRD:  r_den_third  <= i_cfg_data;
                    REG_DEN_FOURTH: r_den_fourth <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smil_percent_conv.sv =====
// Three-stage pipeline that converts a moisture reading to rounded percent.
`timescale 1ns / 1ps
`default_nettype none

module smil_percent_conv #(
    parameter int SAMPLE_FRAC_BITS = 16,
    parameter int ADC_BITS         = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  smil_pkg::t_in_word    i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output smil_pkg::t_conv_word  o_word
);
    import smil_pkg::*;

    localparam int FB = SAMPLE_FRAC_BITS;
    localparam int N  = ADC_BITS;
    localparam int PW = N + 7;
    localparam int CW = FB + 1;
    localparam int VW = N + FB;
    localparam int QW = FB + 7;
    localparam logic [N-1:0] FULL = {N{1'b1}};
    localparam logic [N-1:0] HALF = {1'b0, {(N - 1){1'b1}}};
    localparam longint unsigned RECIP_L = (64'd1 << VW) / ((64'd1 << N) - 64'd1);
    localparam logic [CW-1:0] RECIP = CW'(RECIP_L);
    localparam logic [VW-1:0] FULL_V = VW'(FULL);
    localparam logic [VW-1:0] FULL2_V = VW'(2 * ((64'd1 << N) - 64'd1));

    logic          r_s1_valid;
    logic          r_s1_mode;
    logic [6:0]    r_s1_quo;
    logic [N-1:0]  r_s1_rem;
    logic          r_s2_valid;
    logic          r_s2_mode;
    logic [6:0]    r_s2_quo;
    logic [N-1:0]  r_s2_rem;
    logic [FB-1:0] r_s2_est;
    logic          r_s3_valid;
    t_conv_word    r_s3_word;

    logic          ready1;
    logic          ready2;
    logic          ready3;

    logic [N-1:0]    lim;
    logic [N-1:0]    diff;
    logic [PW-1:0]   scaled;
    logic [6:0]      hi;
    logic [N:0]      fold;
    logic [6:0]      n_s1_quo;
    logic [N-1:0]    n_s1_rem;
    logic [N+CW-1:0] est_prod;
    logic [VW-1:0]   num_v;
    logic [VW-1:0]   est_full;
    logic [VW-1:0]   resid;
    logic [FB-1:0]   q_frac;
    logic [QW-1:0]   q_full;
    t_conv_word      n_s3_word;

    assign ready3  = !r_s3_valid || !i_stall;
    assign ready2  = !r_s2_valid || ready3;
    assign ready1  = !r_s1_valid || ready2;
    assign o_stall = !ready1;
    assign o_valid = r_s3_valid;
    assign o_word  = r_s3_word;

    // Split 100 * (full - reading) into a whole multiple of full scale and a remainder.
    always_comb begin
        if (17'(i_word.adc_sample) > 17'(FULL)) begin
            lim = FULL;
        end else begin
            lim = N'(i_word.adc_sample);
        end
        diff   = FULL - lim;
        scaled = PW'(diff) * PW'(7'd100);
        hi     = scaled[PW-1:N];
        fold   = (N + 1)'(scaled[N-1:0]) + (N + 1)'(hi);
        if (fold >= (N + 1)'(FULL)) begin
            n_s1_rem = N'(fold - (N + 1)'(FULL));
            n_s1_quo = hi + 7'd1;
        end else begin
            n_s1_rem = N'(fold);
            n_s1_quo = hi;
        end
    end

    assign est_prod = (N + CW)'(r_s1_rem) * (N + CW)'(RECIP);

    // The reciprocal estimate falls short by at most two; the residue fixes it.
    always_comb begin
        num_v    = {r_s2_rem, {FB{1'b0}}} + VW'(HALF);
        est_full = {r_s2_est, {N{1'b0}}} - VW'(r_s2_est);
        resid    = num_v - est_full;
        if (resid >= FULL2_V) begin
            q_frac = r_s2_est + FB'(2);
        end else if (resid >= FULL_V) begin
            q_frac = r_s2_est + FB'(1);
        end else begin
            q_frac = r_s2_est;
        end
        q_full                = {r_s2_quo, q_frac};
        n_s3_word.mode        = r_s2_mode;
        n_s3_word.raw_percent = RAW_W'(q_full);
        if (64'(q_full) > 64'(SAMPLE_MAX)) begin
            n_s3_word.sample = SAMPLE_MAX;
        end else begin
            n_s3_word.sample = SAMPLE_W'(q_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r_s1_valid <= i_valid;
            end
            if (ready2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (ready3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_s1_mode <= i_word.mode;
            r_s1_quo  <= n_s1_quo;
            r_s1_rem  <= n_s1_rem;
        end
        if (ready2) begin
            r_s2_mode <= r_s1_mode;
            r_s2_quo  <= r_s1_quo;
            r_s2_rem  <= r_s1_rem;
            r_s2_est  <= est_prod[N+FB-1:N];
        end
        if (ready3) begin
            r_s3_word <= n_s3_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smil_checker.sv =====
// Port checker for the soil moisture filter and its binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "soil_moisture_iir_lowpass_core_macros.svh"

module smil_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  smil_pkg::t_out_word i_out_word
);
    import smil_pkg::*;

    logic in_blocked;
    logic out_held;

    assign in_blocked = i_in_valid && i_in_stall;
    assign out_held   = i_out_valid && i_out_stall;

    // Reset empties the pipeline, so no word is offered in the following cycle.
    `SMIL_ASSERT_RESET(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)

    // A word that is refused at the output stays offered and unchanged.
    `SMIL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, i_out_valid && $stable(i_out_word))

    // The input is refused only when every stage is full behind a stalled output word.
    `SMIL_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, i_in_stall, out_held)

    // A refused input word waits while the output keeps its stalled word.
    `SMIL_ASSERT_NEXT(a_blocked_pair, i_clk, i_rst_n, in_blocked && out_held, i_out_valid)

endmodule

bind soil_moisture_iir_lowpass_core smil_checker u_smil_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out_word (o_out_word)
);

`default_nettype wire

// ===== verif/smil_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the soil moisture filter: mirrors the coefficients, predicts each result word and compares.
module smil_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  smil_pkg::t_in_word          i_in_word,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  smil_pkg::t_out_word         i_out_word,
    input  logic                        i_cfg_we,
    input  logic [smil_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [smil_pkg::COEF_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_words_in,
    output int                          o_words_out,
    output int                          o_due
);

    import smil_pkg::*;

    localparam int NUM_REGS       = int'(REG_DEN_FOURTH) + 1;
    localparam int PERCENT_FRAC   = 16;
    localparam int COEF_FRAC      = 30;
    localparam longint unsigned ADC_FULL = (64'd1 << ADC_IN_W) - 64'd1;

    logic signed [COEF_W-1:0]   coef [NUM_REGS];
    logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] y_hist [HIST_DEPTH];
    t_out_word                  due_results [$];

    function automatic logic [RAW_W-1:0] adc_to_percent(input logic [ADC_IN_W-1:0] adc);
        longint unsigned scaled;
        scaled = ((ADC_FULL - longint'(adc)) * 100) << PERCENT_FRAC;
        return RAW_W'((scaled + ADC_FULL / 2) / ADC_FULL);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
        if (v > longint'(SAMPLE_MAX)) begin
            return SAMPLE_MAX;
        end
        if (v < longint'(SAMPLE_MIN)) begin
            return SAMPLE_MIN;
        end
        return SAMPLE_W'(v);
    endfunction

    task automatic step_filter(input t_in_word w, output t_out_word r);
        logic [RAW_W-1:0]           raw;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        longint                     acc;
        raw = adc_to_percent(w.adc_sample);
        x   = clamp_sample(longint'(raw));
        if (w.mode) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                x_hist[i] = x;
                y_hist[i] = x;
            end
            y = x;
        end else begin
            acc = longint'(coef[REG_NUM_OUTER]) * (longint'(x) + longint'(x_hist[3]))
                + longint'(coef[REG_NUM_MID]) * (longint'(x_hist[0]) + longint'(x_hist[2]))
                + longint'(coef[REG_NUM_CENTER]) * longint'(x_hist[1]);
            for (int i = 0; i < HIST_DEPTH; i++) begin
                acc -= longint'(coef[int'(REG_DEN_FIRST) + i]) * longint'(y_hist[i]);
            end
            acc += longint'(1) << (COEF_FRAC - 1);
            y = clamp_sample(acc >>> COEF_FRAC);
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                x_hist[i] = x_hist[i-1];
                y_hist[i] = y_hist[i-1];
            end
            x_hist[0] = x;
            y_hist[0] = y;
        end
        r.filtered_percent = y;
        r.raw_percent      = raw;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] result word %0d: %s", $time, o_words_out, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word due;
        t_out_word predicted;
        if (!i_rst_n) begin
            coef[REG_NUM_OUTER]  = RST_NUM_OUTER;
            coef[REG_NUM_MID]    = RST_NUM_MID;
            coef[REG_NUM_CENTER] = RST_NUM_CENTER;
            coef[REG_DEN_FIRST]  = RST_DEN_FIRST;
            coef[REG_DEN_SECOND] = RST_DEN_SECOND;
            coef[REG_DEN_THIRD]  = RST_DEN_THIRD;
            coef[REG_DEN_FOURTH] = RST_DEN_FOURTH;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            due_results.delete();
            o_fail_count = 0;
            o_words_in   = 0;
            o_words_out  = 0;
        end else begin
            if (i_cfg_we && i_cfg_index <= REG_DEN_FOURTH) begin
                coef[i_cfg_index] = $signed(i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch("word arrived with no result due");
                end else begin
                    due = due_results.pop_front();
                    if (i_out_word.filtered_percent !== due.filtered_percent) begin
                        report_mismatch($sformatf("filtered_percent is %0d, %0d was due",
                            $signed(i_out_word.filtered_percent),
                            $signed(due.filtered_percent)));
                    end
                    if (i_out_word.raw_percent !== due.raw_percent) begin
                        report_mismatch($sformatf("raw_percent is %0d, %0d was due",
                            i_out_word.raw_percent, due.raw_percent));
                    end
                end
                o_words_out++;
            end
            if (i_in_valid && !i_in_stall) begin
                step_filter(i_in_word, predicted);
                due_results.push_back(predicted);
                o_words_in++;
            end
        end
        o_due = due_results.size();
    end

endmodule

// ===== verif/soil_moisture_iir_lowpass_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the soil moisture filter: drives words and coefficient sets and gives the verdict.
module soil_moisture_iir_lowpass_core_test;

    import smil_pkg::*;

    localparam int NUM_REGS = int'(REG_DEN_FOURTH) + 1;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_PRIME  = 1'b1;
    localparam logic signed [COEF_W-1:0] COEF_UNITY = 34'sh0_4000_0000;
    localparam logic signed [COEF_W-1:0] COEF_TOP   = 34'sh1_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_BOTTOM = 34'sh2_0000_0000;

    typedef logic signed [COEF_W-1:0] t_coef_set [NUM_REGS];

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_word            in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_word           out_word;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [COEF_W-1:0]   cfg_data = '0;

    int fail_count;
    int words_in;
    int words_out;
    int due;
    int sender_idle_pct = 30;
    int receiver_stall_pct = 64;

    soil_moisture_iir_lowpass_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    smil_result_checker watch (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_words_in   (words_in),
        .o_words_out  (words_out),
        .o_due        (due)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic send_word(input logic mode, input logic [ADC_IN_W-1:0] adc);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid           <= 1'b1;
        in_word.mode       <= mode;
        in_word.adc_sample <= adc;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_coefs(input t_coef_set c);
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(r);
            cfg_data  <= c[r];
            @(negedge clk);
        end
        // The spare index must leave every coefficient alone.
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNMAPPED;
        cfg_data  <= COEF_W'({$urandom, $urandom});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained(input int limit);
        int guard;
        guard = 0;
        while (due != 0 && guard < limit) begin
            @(negedge clk);
            guard++;
        end
    endtask

    task automatic run_random(input int count);
        logic                mode;
        logic [ADC_IN_W-1:0] adc;
        int                  pick;
        adc = '0;
        for (int n = 0; n < count; n++) begin
            mode = ($urandom_range(99) < 6) ? MODE_PRIME : MODE_FILTER;
            pick = $urandom_range(99);
            if (pick < 8) begin
                adc = '0;
            end else if (pick < 16) begin
                adc = '1;
            end else if (pick < 50) begin
                adc = adc + ADC_IN_W'($urandom_range(16)) - ADC_IN_W'(8);
            end else begin
                adc = ADC_IN_W'($urandom_range((1 << ADC_IN_W) - 1));
            end
            send_word(mode, adc);
        end
    endtask

    initial begin
        t_coef_set coefs;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients and empty histories first.
        send_word(MODE_FILTER, '1);
        send_word(MODE_FILTER, '0);
        send_word(MODE_FILTER, '0);
        send_word(MODE_FILTER, '0);
        send_word(MODE_FILTER, '0);
        send_word(MODE_FILTER, 10'd1);
        send_word(MODE_FILTER, 10'd1022);
        send_word(MODE_FILTER, 10'h155);
        send_word(MODE_FILTER, 10'h2AA);
        send_word(MODE_FILTER, 10'd511);
        send_word(MODE_FILTER, 10'd512);
        send_word(MODE_PRIME, '0);
        send_word(MODE_FILTER, '0);
        send_word(MODE_FILTER, '0);
        send_word(MODE_FILTER, '0);
        send_word(MODE_PRIME, '1);
        send_word(MODE_FILTER, '1);
        send_word(MODE_FILTER, '0);
        send_word(MODE_PRIME, 10'h2AA);
        send_word(MODE_FILTER, 10'h155);
        in_valid <= 1'b0;
        wait_drained(20000);
        repeat (8) @(negedge clk);

        for (int s = 0; s < 6; s++) begin
            if (s == 2) begin
                sender_idle_pct    = 64;
                receiver_stall_pct = 30;
            end else if (s == 4) begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            case (s)
                0: coefs = '{RST_NUM_OUTER, RST_NUM_MID, RST_NUM_CENTER, RST_DEN_FIRST,
                             RST_DEN_SECOND, RST_DEN_THIRD, RST_DEN_FOURTH};
                1: coefs = '{'0, '0, COEF_UNITY, '0, '0, '0, '0};
                2: coefs = '{default: COEF_TOP};
                3: coefs = '{default: COEF_BOTTOM};
                4: begin
                    for (int r = 0; r < NUM_REGS; r++) begin
                        coefs[r] = COEF_W'({$urandom, $urandom});
                    end
                end
                default: begin
                    for (int r = 0; r < NUM_REGS; r++) begin
                        coefs[r] = COEF_W'(longint'($urandom_range(32'h8000_0000))
                                           - 64'sh4000_0000);
                    end
                end
            endcase
            write_coefs(coefs);
            run_random(280);
            in_valid <= 1'b0;
            wait_drained(20000);
            repeat (8) @(negedge clk);
        end

        repeat (16) @(negedge clk);
        $display("Summary: %0d words sent and %0d results checked over six coefficient sets.",
                 words_in, words_out);
        $display("Both modes, converter extremes and saturating feedback ran under gaps and stalls.");
        if (fail_count == 0 && due == 0) begin
            $display("soil_moisture_iir_lowpass_core_test passed");
        end else begin
            $display("soil_moisture_iir_lowpass_core_test failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results still due.", due);
        $display("soil_moisture_iir_lowpass_core_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/smil_pkg.sv
rtl/smil_percent_conv.sv
rtl/soil_moisture_iir_lowpass_core.sv
rtl/smil_checker.sv
verif/smil_result_checker.sv
verif/soil_moisture_iir_lowpass_core_test.sv
